[rtl/teq_pkg.sv]
// Shared types and codes for the timestamp event queue.
package teq_pkg;

  localparam int TIME_W   = 32;
  localparam int TAG_W    = 16;
  localparam int STATUS_W = 3;

  typedef logic [STATUS_W-1:0] status_t;

  localparam status_t ST_POPPED   = 3'd0;
  localparam status_t ST_EMPTY    = 3'd1;
  localparam status_t ST_CLEARED  = 3'd2;
  localparam status_t ST_INSERTED = 3'd3;
  localparam status_t ST_FULL     = 3'd4;

  localparam logic OP_SCHEDULE = 1'b0;
  localparam logic OP_REMOVE   = 1'b1;

  typedef struct packed {
    logic             opcode;
    logic [TIME_W-1:0] event_time;
    logic [TAG_W-1:0]  event_tag;
  } teq_in_t;

  typedef struct packed {
    status_t           status;
    logic [TIME_W-1:0] out_time;
    logic [TAG_W-1:0]  out_tag;
    logic [TIME_W-1:0] sim_time;
  } teq_out_t;

  typedef struct packed {
    logic [TIME_W-1:0] ev_time;
    logic [TAG_W-1:0]  ev_tag;
  } teq_entry_t;

endpackage

[rtl/teq_ram.sv]
// Entry storage: one write port and one registered read port.
module teq_ram
  import teq_pkg::*;
#(
  parameter int QUEUE_DEPTH = 16
) (
  input  logic                           clk,
  input  logic                           wr_en,
  input  logic [$clog2(QUEUE_DEPTH)-1:0] wr_addr,
  input  teq_entry_t                     wr_data,
  input  logic                           rd_en,
  input  logic [$clog2(QUEUE_DEPTH)-1:0] rd_addr,
  output teq_entry_t                     rd_data
);

  teq_entry_t mem [QUEUE_DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

[rtl/teq_seq.sv]
// Sequencer that keeps the circular sorted queue and walks it with one comparator.
module teq_seq
  import teq_pkg::*;
#(
  parameter int QUEUE_DEPTH = 16
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  teq_in_t                        in_data,
  input  logic [TIME_W-1:0]              end_time,
  output logic                           res_valid,
  input  logic                           res_ready,
  output teq_out_t                       res_data,
  output logic                           wr_en,
  output logic [$clog2(QUEUE_DEPTH)-1:0] wr_addr,
  output teq_entry_t                     wr_data,
  output logic                           rd_en,
  output logic [$clog2(QUEUE_DEPTH)-1:0] rd_addr,
  input  teq_entry_t                     rd_data
);

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam int SUM_W = CNT_W + 1;
  localparam logic [PTR_W-1:0] LAST_IDX = PTR_W'(QUEUE_DEPTH - 1);

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_SCAN  = 5'b00010,
    S_PLACE = 5'b00100,
    S_POP   = 5'b01000,
    S_DONE  = 5'b10000
  } state_t;

  state_t            state, state_next;
  logic [PTR_W-1:0]  head, head_next;
  logic [CNT_W-1:0]  count, count_next;
  logic [TIME_W-1:0] now_time, now_time_next;
  logic [PTR_W-1:0]  idx, idx_next;
  logic [CNT_W-1:0]  remaining, remaining_next;
  logic [TIME_W-1:0] new_time, new_time_next;
  logic [TAG_W-1:0]  new_tag, new_tag_next;
  teq_out_t          result, result_next;

  logic [PTR_W-1:0]  idx_inc, idx_dec, head_inc, last;
  logic [SUM_W-1:0]  last_sum;
  logic [TIME_W-1:0] cmp_a, cmp_b;
  logic              ge;

  assign idx_inc  = (idx == LAST_IDX) ? '0 : idx + PTR_W'(1);
  assign idx_dec  = (idx == '0) ? LAST_IDX : idx - PTR_W'(1);
  assign head_inc = (head == LAST_IDX) ? '0 : head + PTR_W'(1);
  assign last_sum = SUM_W'(head) + SUM_W'(count) - SUM_W'(1);
  assign last     = (last_sum >= SUM_W'(QUEUE_DEPTH)) ?
                    PTR_W'(last_sum - SUM_W'(QUEUE_DEPTH)) : PTR_W'(last_sum);

  // The one comparator serves the insert walk and the end-time check of a pop.
  assign cmp_a = (state == S_POP) ? end_time : rd_data.ev_time;
  assign cmp_b = (state == S_POP) ? rd_data.ev_time : new_time;
  assign ge    = (cmp_a >= cmp_b);

  assign in_ready  = (state == S_IDLE);
  assign res_valid = (state == S_DONE);
  assign res_data  = result;

  always_comb begin
    state_next     = state;
    head_next      = head;
    count_next     = count;
    now_time_next  = now_time;
    idx_next       = idx;
    remaining_next = remaining;
    new_time_next  = new_time;
    new_tag_next   = new_tag;
    result_next    = result;
    wr_en          = 1'b0;
    wr_addr        = idx_inc;
    wr_data        = '{ev_time: new_time, ev_tag: new_tag};
    rd_en          = 1'b0;
    rd_addr        = idx_dec;

    case (state)
      S_IDLE: begin
        if (in_valid) begin
          new_time_next        = in_data.event_time;
          new_tag_next         = in_data.event_tag;
          result_next.out_time = '0;
          result_next.out_tag  = '0;
          result_next.sim_time = now_time;
          if (in_data.opcode == OP_SCHEDULE) begin
            if (count == CNT_W'(QUEUE_DEPTH)) begin
              result_next.status = ST_FULL;
              state_next         = S_DONE;
            end else if (count == '0) begin
              wr_en              = 1'b1;
              wr_addr            = head;
              wr_data            = '{ev_time: in_data.event_time, ev_tag: in_data.event_tag};
              count_next         = count + CNT_W'(1);
              result_next.status = ST_INSERTED;
              state_next         = S_DONE;
            end else begin
              rd_en          = 1'b1;
              rd_addr        = last;
              idx_next       = last;
              remaining_next = count;
              state_next     = S_SCAN;
            end
          end else begin
            if (count == '0) begin
              result_next.status = ST_EMPTY;
              state_next         = S_DONE;
            end else begin
              rd_en      = 1'b1;
              rd_addr    = head;
              state_next = S_POP;
            end
          end
        end
      end
      S_SCAN: begin
        wr_en = 1'b1;
        if (ge) begin
          wr_data        = rd_data;
          idx_next       = idx_dec;
          remaining_next = remaining - CNT_W'(1);
          if (remaining == CNT_W'(1)) begin
            state_next = S_PLACE;
          end else begin
            rd_en = 1'b1;
          end
        end else begin
          count_next         = count + CNT_W'(1);
          result_next.status = ST_INSERTED;
          state_next         = S_DONE;
        end
      end
      S_PLACE: begin
        wr_en              = 1'b1;
        count_next         = count + CNT_W'(1);
        result_next.status = ST_INSERTED;
        state_next         = S_DONE;
      end
      S_POP: begin
        now_time_next        = rd_data.ev_time;
        result_next.sim_time = rd_data.ev_time;
        if (ge) begin
          head_next            = head_inc;
          count_next           = count - CNT_W'(1);
          result_next.status   = ST_POPPED;
          result_next.out_time = rd_data.ev_time;
          result_next.out_tag  = rd_data.ev_tag;
        end else begin
          count_next         = '0;
          result_next.status = ST_CLEARED;
        end
        state_next = S_DONE;
      end
      S_DONE: begin
        if (res_ready) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      head     <= '0;
      count    <= '0;
      now_time <= '0;
    end else begin
      state    <= state_next;
      head     <= head_next;
      count    <= count_next;
      now_time <= now_time_next;
    end
  end

  always_ff @(posedge clk) begin
    idx       <= idx_next;
    remaining <= remaining_next;
    new_time  <= new_time_next;
    new_tag   <= new_tag_next;
    result    <= result_next;
  end

endmodule

[rtl/timestamp_event_queue_core.sv]
// Top level of the timestamp-ordered future event queue.
// The input channel (in_valid, in_ready, in_data) takes one beat per command:
// schedule an event with a timestamp and tag, or remove the earliest event.
// Every input beat produces exactly one output beat (out_valid, out_ready,
// out_data) with a status, the popped timestamp and tag, and the simulation
// time. cfg_wr_en with cfg_wr_data sets the end time at any idle moment.
// Entries live in a circular buffer ordered by timestamp. A schedule walks
// backward from the newest end with a single comparator, moving one entry per
// cycle through the one RAM port. A remove reads the head; if its timestamp
// lies past the end time, the queue is cleared instead of popped.
// The block takes one command at a time; in_ready is high only while idle.
// A finished beat sits in the output register, so the next command is
// accepted while the receiver stalls; a second result waits inside until the
// output register drains. Reset is synchronous: it empties the queue, sets
// the simulation time to zero and the end time to all ones.
module timestamp_event_queue_core
  import teq_pkg::*;
#(
  parameter int QUEUE_DEPTH = 16
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  teq_in_t           in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output teq_out_t          out_data,
  input  logic              cfg_wr_en,
  input  logic [TIME_W-1:0] cfg_wr_data
);

  localparam int PTR_W = $clog2(QUEUE_DEPTH);

  logic [TIME_W-1:0] end_time;
  logic              res_valid, res_ready;
  teq_out_t          res_data;
  logic              wr_en, rd_en;
  logic [PTR_W-1:0]  wr_addr, rd_addr;
  teq_entry_t        wr_data, rd_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      end_time <= '1;
    end else if (cfg_wr_en) begin
      end_time <= cfg_wr_data;
    end
  end

  assign res_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_ready) begin
      out_valid <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      out_data <= res_data;
    end
  end

  teq_seq #(
    .QUEUE_DEPTH(QUEUE_DEPTH)
  ) u_seq (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .end_time (end_time),
    .res_valid(res_valid),
    .res_ready(res_ready),
    .res_data (res_data),
    .wr_en    (wr_en),
    .wr_addr  (wr_addr),
    .wr_data  (wr_data),
    .rd_en    (rd_en),
    .rd_addr  (rd_addr),
    .rd_data  (rd_data)
  );

  teq_ram #(
    .QUEUE_DEPTH(QUEUE_DEPTH)
  ) u_ram (
    .clk    (clk),
    .wr_en  (wr_en),
    .wr_addr(wr_addr),
    .wr_data(wr_data),
    .rd_en  (rd_en),
    .rd_addr(rd_addr),
    .rd_data(rd_data)
  );

endmodule

[dv/timestamp_event_queue_core_tb.sv]
// Self-checking testbench for the timestamp event queue core with a built-in queue predictor.
module timestamp_event_queue_core_tb;
  import teq_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int DEPTH = 16;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              in_valid = 1'b0;
  logic              in_ready;
  teq_in_t           in_data = '0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  teq_out_t          out_data;
  logic              cfg_wr_en = 1'b0;
  logic [TIME_W-1:0] cfg_wr_data = '0;

  teq_entry_t        ev_list[DEPTH];
  int                ev_count = 0;
  logic [TIME_W-1:0] now_tick = '0;
  logic [TIME_W-1:0] end_tick = '1;

  teq_out_t          pending_results[$];
  int                fails = 0;
  bit                send_idle = 1'b1;
  bit                recv_idle = 1'b1;
  bit                valid_held = 1'b0;

  timestamp_event_queue_core #(
    .QUEUE_DEPTH(DEPTH)
  ) u_dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data(out_data),
    .cfg_wr_en(cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic teq_out_t queue_result(teq_in_t cmd);
    teq_out_t   r;
    teq_entry_t head;
    int         pos;
    int         k;
    r = '0;
    if (cmd.opcode == OP_SCHEDULE) begin
      if (ev_count >= DEPTH) begin
        r.status = ST_FULL;
      end else begin
        pos = 0;
        while (pos < ev_count && ev_list[pos].ev_time < cmd.event_time) pos++;
        for (k = ev_count; k > pos; k--) ev_list[k] = ev_list[k-1];
        ev_list[pos].ev_time = cmd.event_time;
        ev_list[pos].ev_tag = cmd.event_tag;
        ev_count++;
        r.status = ST_INSERTED;
      end
    end else if (ev_count == 0) begin
      r.status = ST_EMPTY;
    end else begin
      head = ev_list[0];
      for (k = 1; k < ev_count; k++) ev_list[k-1] = ev_list[k];
      ev_count--;
      now_tick = head.ev_time;
      if (head.ev_time > end_tick) begin
        ev_count = 0;
        r.status = ST_CLEARED;
      end else begin
        r.status = ST_POPPED;
        r.out_time = head.ev_time;
        r.out_tag = head.ev_tag;
      end
    end
    r.sim_time = now_tick;
    return r;
  endfunction

  task automatic send_cmd(input logic op, input logic [TIME_W-1:0] t,
                          input logic [TAG_W-1:0] tag);
    int      gap;
    teq_in_t cmd;
    gap = send_idle ? $urandom_range(0, 19) : 0;
    cmd.opcode = op;
    cmd.event_time = t;
    cmd.event_tag = tag;
    if (gap > 0) begin
      if (valid_held) begin
        in_valid <= 1'b0;
        valid_held = 1'b0;
      end
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    valid_held = 1'b1;
    in_data <= cmd;
    do @(posedge clk); while (!in_ready);
    pending_results.push_back(queue_result(cmd));
  endtask

  task automatic wait_drain();
    if (valid_held) begin
      in_valid <= 1'b0;
      valid_held = 1'b0;
    end
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic set_end_time(input logic [TIME_W-1:0] value);
    wait_drain();
    repeat (4) @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    end_tick = value;
  endtask

  // Runs with the end time still at its reset value of all ones.
  task automatic test_ordering_extremes();
    send_cmd(OP_REMOVE, $urandom(), TAG_W'($urandom()));
    send_cmd(OP_SCHEDULE, 32'hFFFF_FFFF, 16'hFFFF);
    send_cmd(OP_SCHEDULE, 32'h0, 16'h0000);
    send_cmd(OP_SCHEDULE, 32'h0, 16'h0001);
    repeat (3) send_cmd(OP_REMOVE, $urandom(), TAG_W'($urandom()));
  endtask

  task automatic test_full_queue_and_end_time();
    int i;
    set_end_time(32'h8000_0000);
    for (i = 0; i < DEPTH; i++) begin
      send_cmd(OP_SCHEDULE, 32'h8000_0000 + ((i * 7) % DEPTH), TAG_W'($urandom()));
    end
    send_cmd(OP_SCHEDULE, 32'h0, TAG_W'($urandom()));
    repeat (3) send_cmd(OP_REMOVE, $urandom(), TAG_W'($urandom()));
  endtask

  task automatic test_random_traffic();
    logic [TIME_W-1:0] end_values[5];
    logic [TIME_W-1:0] t;
    bit                fill;
    int                p;
    int                n;
    end_values[0] = 32'hFFFF_FFFF;
    end_values[1] = 32'h0;
    end_values[2] = 32'h8000_0000;
    end_values[3] = $urandom();
    end_values[4] = 32'hFFFF_FFFE;
    fill = 1'b1;
    for (p = 0; p < 5; p++) begin
      set_end_time(end_values[p]);
      for (n = 0; n < 175; n++) begin
        if (n % 25 == 0) begin
          send_idle = ($urandom_range(0, 2) != 0);
          recv_idle = ($urandom_range(0, 2) != 0);
        end
        if ($urandom_range(0, 15) == 0) fill = !fill;
        case ($urandom_range(0, 4))
          0: t = $urandom_range(0, 15);
          1: t = $urandom();
          2: t = end_tick + $urandom_range(0, 4) - 2;
          3: t = $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'h0;
          default: t = now_tick + $urandom_range(0, 1000);
        endcase
        if ($urandom_range(0, 99) < (fill ? 75 : 30)) begin
          send_cmd(OP_SCHEDULE, t, TAG_W'($urandom()));
        end else begin
          send_cmd(OP_REMOVE, t, TAG_W'($urandom()));
        end
      end
    end
  endtask

  initial begin : result_checker
    int       stall;
    bit       ready_held;
    teq_out_t got;
    teq_out_t want;
    ready_held = 1'b0;
    do @(posedge clk); while (rst);
    forever begin
      stall = recv_idle ? $urandom_range(0, 19) : 0;
      if (stall > 0) begin
        if (ready_held) begin
          out_ready <= 1'b0;
          ready_held = 1'b0;
        end
        repeat (stall) @(posedge clk);
      end
      if (!ready_held) begin
        out_ready <= 1'b1;
        ready_held = 1'b1;
      end
      do @(posedge clk); while (!out_valid);
      got = out_data;
      if (pending_results.size() == 0) begin
        $error("result beat with nothing expected: %h", got);
        fails++;
      end else begin
        want = pending_results.pop_front();
        if (got.status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, got.status);
          fails++;
        end
        if (got.out_time !== want.out_time) begin
          $error("out_time: expected %h, got %h", want.out_time, got.out_time);
          fails++;
        end
        if (got.out_tag !== want.out_tag) begin
          $error("out_tag: expected %h, got %h", want.out_tag, got.out_tag);
          fails++;
        end
        if (got.sim_time !== want.sim_time) begin
          $error("sim_time: expected %h, got %h", want.sim_time, got.sim_time);
          fails++;
        end
      end
    end
  end

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    test_ordering_extremes();
    test_full_queue_and_end_time();
    test_random_traffic();
    wait_drain();
    repeat (20) @(posedge clk);
    if (fails == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule
